// ----- src/rrts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and codes of the round-robin task scheduler
// Event opcodes, result status codes and the layout of one task slot entry.
// ----------------------------------------------------------------------------
package rrts_pkg;

    // Field widths that the interface fixes.
    localparam int OPCODE_W = 3;
    localparam int TASK_W   = 3;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;
    localparam int TIU_W    = 4;

    // Event opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SEND  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_WAKE  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SLEEP = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PICK  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_DONE  = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RUNNABLE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TASKS_IN_USE = 2'd0;
    localparam logic [1:0] CFG_QUEUE_CAP    = 2'd1;
    localparam logic [1:0] CFG_WAIT_FOREVER = 2'd2;

    // State kept for one task slot.
    typedef struct packed {
        logic [VALUE_W-1:0] sleep_timer;
        logic               timer_expired;
        logic               asleep;
        logic [COUNT_W-1:0] pending_messages;
        logic [VALUE_W-1:0] wake_kind;
    } task_entry_t;

endpackage

// ----- src/rrts_task_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_task_bank: per-task state storage
// One entry per task slot, read and written back at a single shared address.
// ----------------------------------------------------------------------------
module rrts_task_bank #(
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  logic                       wr_en,
    input  rrts_pkg::task_entry_t      wr_entry,
    output rrts_pkg::task_entry_t      rd_entry
);

    localparam int AW = $clog2(DEPTH);

    rrts_pkg::task_entry_t entry_reg [DEPTH];

    // Read port; slots past the depth read as an empty task.
    always_comb
    begin
        if ({1'b0, addr} < (AW + 1)'(DEPTH))
        begin
            rd_entry = entry_reg[addr];
        end
        else
        begin
            rd_entry = '0;
        end
    end

    // Write port; every slot starts cleared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr_en && ({1'b0, addr} < (AW + 1)'(DEPTH)))
        begin
            entry_reg[addr] <= wr_entry;
        end
    end

endmodule

// ----- src/round_robin_task_scheduler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit: round-robin scheduler with sleep timers
// Event-driven task scheduler: tick, send, wake, sleep, pick and task done.
// ----------------------------------------------------------------------------
// The block takes one event at a time and returns exactly one result for it.
// All task state sits in a bank that is read and written at one slot per
// cycle by a small sequencer, so the cost of an event is set by how many slots
// it visits: send, wake, sleep, done and unknown opcodes visit one slot, tick
// visits every slot of a ring of N tasks, and pick visits the K slots that it
// checks (at most N, and 1 while switching is inhibited). The input is ready
// again once the result is handed to the output register; a waiting result
// does not block the next input transfer. Configuration writes take effect at
// once and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit #(
    parameter int MAX_TASKS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Event input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [2:0]  task_index,
    input  logic [15:0] value,
    input  logic        switch_permit,
    // Result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [2:0]  chosen_task,
    output logic        had_message,
    output logic        timer_event,
    output logic [15:0] wake_kind
);

    localparam int IDX_W      = $clog2(MAX_TASKS);
    localparam int RING_W     = $clog2(MAX_TASKS + 1);
    localparam int CMP_W      = (RING_W > rrts_pkg::TIU_W) ? RING_W : rrts_pkg::TIU_W;
    localparam int IW         = (RING_W > rrts_pkg::TASK_W) ? RING_W : rrts_pkg::TASK_W;
    localparam int RESET_RING = (MAX_TASKS < 8) ? MAX_TASKS : 8;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Apply a returned or requested delay to one task entry.
    function automatic rrts_pkg::task_entry_t apply_delay(
        input rrts_pkg::task_entry_t e,
        input logic [15:0]           d,
        input logic [15:0]           forever_code
    );
        rrts_pkg::task_entry_t r;
        r = e;
        if (d == '0)
        begin
            r.timer_expired = 1'b1;
            r.sleep_timer   = '0;
        end
        else if (d == forever_code)
        begin
            r.timer_expired = 1'b0;
            r.sleep_timer   = '0;
        end
        else
        begin
            r.timer_expired = 1'b0;
            r.sleep_timer   = d;
        end
        return r;
    endfunction

    // Configuration registers
    logic [3:0]  tasks_in_use_reg;
    logic [7:0]  queue_capacity_reg;
    logic [15:0] wait_forever_reg;

    // Sequencer and scheduler registers
    logic [1:0]       state_reg, state_next;
    logic [2:0]       op_reg;
    logic [2:0]       idx_reg;
    logic [15:0]      val_reg;
    logic             permit_reg;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [RING_W-1:0] remain_reg, remain_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             sw_reg, sw_next;

    // Result being built and the output register
    logic [1:0]  res_status_reg, res_status_next;
    logic        res_had_reg, res_had_next;
    logic        res_tev_reg, res_tev_next;
    logic [15:0] res_kind_reg, res_kind_next;
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [2:0]  chosen_reg;
    logic        had_reg;
    logic        tev_reg;
    logic [15:0] kind_reg;

    // Bank port and helpers
    logic [IDX_W-1:0]      bank_addr;
    logic                  bank_wr_en;
    rrts_pkg::task_entry_t bank_wr;
    rrts_pkg::task_entry_t bank_rd;
    logic [CMP_W-1:0]      tiu_wide;
    logic [CMP_W-1:0]      ring_wide;
    logic [RING_W-1:0]     ring_n;
    logic [RING_W-1:0]     cur_plus;
    logic [IDX_W-1:0]      cur_succ;
    logic [IDX_W-1:0]      pick_slot;
    logic [IDX_W+2:0]      idx_slot_wide;
    logic [IDX_W+2:0]      chosen_wide;
    logic                  idx_out_of_ring;
    logic                  in_xfer;
    logic                  out_load;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Ring size: zero acts as one, anything above the slot count is clamped.
    always_comb
    begin
        tiu_wide = CMP_W'(tasks_in_use_reg);
        if (tiu_wide == '0)
        begin
            ring_wide = CMP_W'(1);
        end
        else if (tiu_wide > CMP_W'(MAX_TASKS))
        begin
            ring_wide = CMP_W'(MAX_TASKS);
        end
        else
        begin
            ring_wide = tiu_wide;
        end
    end
    assign ring_n = ring_wide[RING_W-1:0];

    // Next task around the ring, and the slot a pick step checks.
    assign cur_plus  = RING_W'(cur_reg) + RING_W'(1);
    assign cur_succ  = (cur_plus >= ring_n) ? '0 : cur_plus[IDX_W-1:0];
    assign pick_slot = sw_reg ? cur_succ : cur_reg;

    assign idx_slot_wide   = {{IDX_W{1'b0}}, idx_reg};
    assign idx_out_of_ring = IW'(idx_reg) >= IW'(ring_n);
    assign chosen_wide     = {3'b000, cur_reg};

    // Shared slot address for the task bank.
    always_comb
    begin
        case (op_reg)
            rrts_pkg::OP_TICK:  bank_addr = slot_reg;
            rrts_pkg::OP_SEND:  bank_addr = idx_slot_wide[IDX_W-1:0];
            rrts_pkg::OP_WAKE:  bank_addr = idx_slot_wide[IDX_W-1:0];
            rrts_pkg::OP_PICK:  bank_addr = pick_slot;
            default:            bank_addr = cur_reg;
        endcase
    end

    rrts_task_bank #(
        .DEPTH (MAX_TASKS)
    ) u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .addr     (bank_addr),
        .wr_en    (bank_wr_en),
        .wr_entry (bank_wr),
        .rd_entry (bank_rd)
    );

    // Sequencer: one slot is read, updated and written back each cycle.
    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        remain_next     = remain_reg;
        cur_next        = cur_reg;
        sw_next         = sw_reg;
        res_status_next = res_status_reg;
        res_had_next    = res_had_reg;
        res_tev_next    = res_tev_reg;
        res_kind_next   = res_kind_reg;
        bank_wr_en      = 1'b0;
        bank_wr         = bank_rd;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next      = S_RUN;
                    slot_next       = '0;
                    res_status_next = rrts_pkg::ST_OK;
                    res_had_next    = 1'b0;
                    res_tev_next    = 1'b0;
                    res_kind_next   = '0;
                    if (opcode == rrts_pkg::OP_PICK && !sw_reg)
                    begin
                        remain_next = RING_W'(1);
                    end
                    else
                    begin
                        remain_next = ring_n;
                    end
                end
            end

            S_RUN:
            begin
                state_next = S_DONE;
                case (op_reg)
                    rrts_pkg::OP_TICK:
                    begin
                        // Count down one nonzero timer per cycle.
                        if (bank_rd.sleep_timer != '0)
                        begin
                            bank_wr_en          = 1'b1;
                            bank_wr.sleep_timer = bank_rd.sleep_timer - 16'd1;
                            if (bank_rd.sleep_timer == 16'd1)
                            begin
                                bank_wr.timer_expired = 1'b1;
                            end
                        end
                        if (remain_reg != RING_W'(1))
                        begin
                            state_next  = S_RUN;
                            slot_next   = slot_reg + IDX_W'(1);
                            remain_next = remain_reg - RING_W'(1);
                        end
                    end

                    rrts_pkg::OP_SEND:
                    begin
                        if (idx_out_of_ring ||
                            bank_rd.pending_messages >= queue_capacity_reg)
                        begin
                            res_status_next = rrts_pkg::ST_QUEUE_FULL;
                        end
                        else
                        begin
                            bank_wr_en               = 1'b1;
                            bank_wr.pending_messages = bank_rd.pending_messages + 8'd1;
                        end
                    end

                    rrts_pkg::OP_WAKE:
                    begin
                        if (!idx_out_of_ring && bank_rd.asleep && !bank_rd.timer_expired)
                        begin
                            bank_wr_en            = 1'b1;
                            bank_wr.timer_expired = 1'b1;
                            bank_wr.wake_kind     = val_reg;
                        end
                    end

                    rrts_pkg::OP_SLEEP:
                    begin
                        bank_wr_en        = 1'b1;
                        bank_wr           = apply_delay(bank_rd, val_reg, wait_forever_reg);
                        bank_wr.asleep    = 1'b1;
                        bank_wr.wake_kind = '0;
                        sw_next           = permit_reg;
                    end

                    rrts_pkg::OP_DONE:
                    begin
                        bank_wr_en = 1'b1;
                        bank_wr    = apply_delay(bank_rd, val_reg, wait_forever_reg);
                    end

                    rrts_pkg::OP_PICK:
                    begin
                        // Check one candidate per cycle; stop at the first runnable one.
                        cur_next = pick_slot;
                        if (bank_rd.asleep && bank_rd.timer_expired)
                        begin
                            bank_wr_en            = 1'b1;
                            bank_wr.sleep_timer   = '0;
                            bank_wr.timer_expired = 1'b0;
                            bank_wr.asleep        = 1'b0;
                            sw_next               = 1'b1;
                            res_tev_next          = 1'b1;
                        end
                        else if (!bank_rd.asleep &&
                                 (bank_rd.pending_messages != '0 || bank_rd.timer_expired))
                        begin
                            bank_wr_en   = 1'b1;
                            res_tev_next = bank_rd.timer_expired;
                        end

                        if (bank_wr_en)
                        begin
                            if (bank_rd.pending_messages != '0)
                            begin
                                bank_wr.pending_messages = bank_rd.pending_messages - 8'd1;
                                res_had_next             = 1'b1;
                            end
                            res_kind_next   = bank_rd.wake_kind;
                            res_status_next = rrts_pkg::ST_OK;
                        end
                        else if (remain_reg != RING_W'(1))
                        begin
                            state_next  = S_RUN;
                            remain_next = remain_reg - RING_W'(1);
                        end
                        else
                        begin
                            res_status_next = rrts_pkg::ST_NO_RUNNABLE;
                        end
                    end

                    default:
                    begin
                        bank_wr_en = 1'b0;
                    end
                endcase
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tasks_in_use_reg   <= 4'd8;
            queue_capacity_reg <= 8'd16;
            wait_forever_reg   <= 16'hFFFF;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                rrts_pkg::CFG_TASKS_IN_USE: tasks_in_use_reg   <= cfg_data[3:0];
                rrts_pkg::CFG_QUEUE_CAP:    queue_capacity_reg <= cfg_data[7:0];
                rrts_pkg::CFG_WAIT_FOREVER: wait_forever_reg   <= cfg_data;
                default:                    tasks_in_use_reg   <= tasks_in_use_reg;
            endcase
        end
    end

    // Sequencer control and scheduler state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_reg       <= '0;
            remain_reg     <= '0;
            cur_reg        <= IDX_W'(RESET_RING - 1);
            sw_reg         <= 1'b1;
            res_status_reg <= rrts_pkg::ST_OK;
            res_had_reg    <= 1'b0;
            res_tev_reg    <= 1'b0;
            res_kind_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            remain_reg     <= remain_next;
            cur_reg        <= cur_next;
            sw_reg         <= sw_next;
            res_status_reg <= res_status_next;
            res_had_reg    <= res_had_next;
            res_tev_reg    <= res_tev_next;
            res_kind_reg   <= res_kind_next;
        end
    end

    // Captured event fields.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg     <= opcode;
            idx_reg    <= task_index;
            val_reg    <= value;
            permit_reg <= switch_permit;
        end
    end

    // Output register: holds a finished result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= res_status_reg;
            chosen_reg <= chosen_wide[2:0];
            had_reg    <= res_had_reg;
            tev_reg    <= res_tev_reg;
            kind_reg   <= res_kind_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign chosen_task = chosen_reg;
    assign had_message = had_reg;
    assign timer_event = tev_reg;
    assign wake_kind   = kind_reg;

endmodule

// ----- src/rrts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_checker: port-level checks for the task scheduler
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
module rrts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [2:0]  chosen_task,
    input logic        had_message,
    input logic        timer_event,
    input logic [15:0] wake_kind
);

    // A stalled result keeps its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(chosen_task)
            && $stable(had_message) && $stable(timer_event) && $stable(wake_kind))
    else $error("stalled result changed");

    // The block works on one event at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an input transfer");

    // Status never carries the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == rrts_pkg::ST_OK || status == rrts_pkg::ST_QUEUE_FULL
            || status == rrts_pkg::ST_NO_RUNNABLE)
    else $error("undefined status code");

    // Dispatch details appear only in a successful result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != rrts_pkg::ST_OK |->
            !had_message && !timer_event && wake_kind == 16'd0)
    else $error("dispatch fields set in a failed result");

endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (.*);

// ----- tb/sv/round_robin_task_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit_tb: self-checking bench for the scheduler
// Sends tick, send, wake, sleep, pick and done events through the event port,
// with directed cases first and then random kernel-like event sequences under
// several ring sizes, queue capacities and wait-forever codes. A scoreboard
// keeps its own copy of every task slot, works out the result of each accepted
// event and compares it field by field with what the block returns. Both
// sides idle at random, and the output is held off for a long stretch once.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit_tb;

    localparam int          TASK_SLOTS    = 8;
    localparam int          SETTLE_CYCLES = TASK_SLOTS + 6;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          IDLE_PERCENT  = 37;

    // Opcodes the block treats as no operation, and the unused register slot.
    localparam logic [rrts_pkg::OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [rrts_pkg::OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [1:0]                    CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic [rrts_pkg::STATUS_W-1:0] status;
        logic [rrts_pkg::TASK_W-1:0]   chosen_task;
        logic                          had_message;
        logic                          timer_event;
        logic [rrts_pkg::VALUE_W-1:0]  wake_kind;
    } sched_result_t;

    // Clock, reset and block ports.
    logic                          clk;
    logic                          rst_n         = 1'b0;
    logic                          cfg_write_en  = 1'b0;
    logic [1:0]                    cfg_index     = '0;
    logic [15:0]                   cfg_data      = '0;
    logic                          in_valid      = 1'b0;
    logic                          in_ready;
    logic [rrts_pkg::OPCODE_W-1:0] opcode        = '0;
    logic [rrts_pkg::TASK_W-1:0]   task_index    = '0;
    logic [rrts_pkg::VALUE_W-1:0]  value         = '0;
    logic                          switch_permit = 1'b0;
    logic                          out_valid;
    logic                          out_ready     = 1'b0;
    logic [rrts_pkg::STATUS_W-1:0] status;
    logic [rrts_pkg::TASK_W-1:0]   chosen_task;
    logic                          had_message;
    logic                          timer_event;
    logic [rrts_pkg::VALUE_W-1:0]  wake_kind;

    // Scoreboard copy of the task slots and the configuration.
    logic [rrts_pkg::VALUE_W-1:0]  slot_timer   [TASK_SLOTS];
    logic                          slot_flag    [TASK_SLOTS];
    logic                          slot_asleep  [TASK_SLOTS];
    logic [rrts_pkg::COUNT_W-1:0]  slot_msgs    [TASK_SLOTS];
    logic [rrts_pkg::VALUE_W-1:0]  slot_kind    [TASK_SLOTS];
    int unsigned                   running_task;
    logic                          may_switch;
    logic [rrts_pkg::TIU_W-1:0]    cfg_ring;
    logic [rrts_pkg::COUNT_W-1:0]  cfg_cap;
    logic [rrts_pkg::VALUE_W-1:0]  cfg_forever;

    sched_result_t       expected_q [$];
    int unsigned         fail_count     = 0;
    int unsigned         items_sent     = 0;
    int unsigned         cycle_count    = 0;
    int unsigned         stall_requests = 0;
    int unsigned         stall_seen     = 0;
    int unsigned         hold_left      = 0;
    bit                  steady_stream  = 1'b0;

    round_robin_task_scheduler_unit #(
        .MAX_TASKS(TASK_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .task_index   (task_index),
        .value        (value),
        .switch_permit(switch_permit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .chosen_task  (chosen_task),
        .had_message  (had_message),
        .timer_event  (timer_event),
        .wake_kind    (wake_kind)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("round_robin_task_scheduler_unit test failed");
            $finish;
        end
    end

    // Result receiver: random back-pressure, a long hold-off on request, none when steady.
    always @(posedge clk)
    begin
        if (stall_seen != stall_requests)
        begin
            stall_seen = stall_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (steady_stream)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Result checker: every output transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: status %0d, chosen_task %0d", status, chosen_task);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (chosen_task !== want.chosen_task)
                begin
                    $error("chosen_task: expected %0d, actual %0d", want.chosen_task,
                           chosen_task);
                    fail_count++;
                end
                if (had_message !== want.had_message)
                begin
                    $error("had_message: expected %0d, actual %0d", want.had_message,
                           had_message);
                    fail_count++;
                end
                if (timer_event !== want.timer_event)
                begin
                    $error("timer_event: expected %0d, actual %0d", want.timer_event,
                           timer_event);
                    fail_count++;
                end
                if (wake_kind !== want.wake_kind)
                begin
                    $error("wake_kind: expected 0x%04h, actual 0x%04h", want.wake_kind,
                           wake_kind);
                    fail_count++;
                end
            end
        end
    end

    // Number of tasks in the ring, with out-of-range register values clamped.
    function automatic int unsigned ring_len();
        if (cfg_ring == 0)
            return 1;
        if (cfg_ring > TASK_SLOTS)
            return TASK_SLOTS;
        return 32'(cfg_ring);
    endfunction

    // Scoreboard state after reset.
    function automatic void clear_slots();
        for (int t = 0; t < TASK_SLOTS; t++)
        begin
            slot_timer[t]  = '0;
            slot_flag[t]   = 1'b0;
            slot_asleep[t] = 1'b0;
            slot_msgs[t]   = '0;
            slot_kind[t]   = '0;
        end
        cfg_ring     = 4'd8;
        cfg_cap      = 8'd16;
        cfg_forever  = 16'hFFFF;
        may_switch   = 1'b1;
        running_task = ring_len() - 1;
    endfunction

    // A delay of zero flags the timer at once, the wait-forever code disarms it.
    function automatic void arm_timer(input int unsigned t,
                                      input logic [rrts_pkg::VALUE_W-1:0] delay);
        if (delay == 0)
        begin
            slot_flag[t]  = 1'b1;
            slot_timer[t] = '0;
        end
        else if (delay == cfg_forever)
        begin
            slot_timer[t] = '0;
            slot_flag[t]  = 1'b0;
        end
        else
        begin
            slot_timer[t] = delay;
            slot_flag[t]  = 1'b0;
        end
    endfunction

    // Applies one event to the scoreboard state and returns the result it causes.
    function automatic sched_result_t schedule_event(
        input logic [rrts_pkg::OPCODE_W-1:0] op,
        input logic [rrts_pkg::TASK_W-1:0]   idx,
        input logic [rrts_pkg::VALUE_W-1:0]  val,
        input logic                          permit
    );
        sched_result_t res;
        int unsigned   n;
        int unsigned   t;
        int unsigned   laps;
        bit            found;
        res   = '0;
        n     = ring_len();
        found = 1'b0;
        case (op)
            rrts_pkg::OP_TICK:
            begin
                for (t = 0; t < n; t++)
                begin
                    if (slot_timer[t] != 0)
                    begin
                        slot_timer[t] = slot_timer[t] - 16'd1;
                        if (slot_timer[t] == 0)
                            slot_flag[t] = 1'b1;
                    end
                end
            end
            rrts_pkg::OP_SEND:
            begin
                if (idx >= n || slot_msgs[idx] >= cfg_cap)
                    res.status = rrts_pkg::ST_QUEUE_FULL;
                else
                    slot_msgs[idx] = slot_msgs[idx] + 8'd1;
            end
            rrts_pkg::OP_WAKE:
            begin
                if (idx < n && slot_asleep[idx] && !slot_flag[idx])
                begin
                    slot_flag[idx] = 1'b1;
                    slot_kind[idx] = val;
                end
            end
            rrts_pkg::OP_SLEEP:
            begin
                slot_asleep[running_task] = 1'b1;
                slot_kind[running_task]   = '0;
                arm_timer(running_task, val);
                may_switch = permit;
            end
            rrts_pkg::OP_PICK:
            begin
                res.status = rrts_pkg::ST_NO_RUNNABLE;
                laps = may_switch ? n : 1;
                for (int k = 0; k < laps && !found; k++)
                begin
                    if (may_switch)
                        running_task = (running_task + 1 >= n) ? 0 : running_task + 1;
                    t = running_task;
                    if (slot_asleep[t])
                    begin
                        // A sleeper whose timer ran out or that was woken is resumed.
                        if (slot_flag[t])
                        begin
                            slot_timer[t]  = '0;
                            slot_flag[t]   = 1'b0;
                            slot_asleep[t] = 1'b0;
                            may_switch     = 1'b1;
                            res.timer_event = 1'b1;
                            found = 1'b1;
                        end
                    end
                    else if (slot_msgs[t] != 0 || slot_flag[t])
                    begin
                        res.timer_event = slot_flag[t];
                        found = 1'b1;
                    end
                    if (found)
                    begin
                        if (slot_msgs[t] != 0)
                        begin
                            slot_msgs[t]    = slot_msgs[t] - 8'd1;
                            res.had_message = 1'b1;
                        end
                        res.wake_kind = slot_kind[t];
                        res.status    = rrts_pkg::ST_OK;
                    end
                end
            end
            rrts_pkg::OP_DONE:
                arm_timer(running_task, val);
            default:
            begin
            end
        endcase
        res.chosen_task = running_task[rrts_pkg::TASK_W-1:0];
        return res;
    endfunction

    // Offers one event, waits for its transfer and records the result it must cause.
    task automatic send_event(input logic [rrts_pkg::OPCODE_W-1:0] op,
                              input logic [rrts_pkg::TASK_W-1:0]   idx,
                              input logic [rrts_pkg::VALUE_W-1:0]  val,
                              input logic                          permit);
        int unsigned gap;
        if (!steady_stream && $urandom_range(99) < IDLE_PERCENT)
        begin
            gap = $urandom_range(3, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        task_index    <= idx;
        value         <= val;
        switch_permit <= permit;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(schedule_event(op, idx, val, permit));
        items_sent++;
    endtask

    // Stops offering events until every expected result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // One register write; the scoreboard follows the same write.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            rrts_pkg::CFG_TASKS_IN_USE: cfg_ring    = data[rrts_pkg::TIU_W-1:0];
            rrts_pkg::CFG_QUEUE_CAP:    cfg_cap     = data[rrts_pkg::COUNT_W-1:0];
            rrts_pkg::CFG_WAIT_FOREVER: cfg_forever = data;
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    // Reconfigures the block once it has gone idle.
    task automatic set_config(input logic [rrts_pkg::TIU_W-1:0]   ring,
                              input logic [rrts_pkg::COUNT_W-1:0] cap,
                              input logic [rrts_pkg::VALUE_W-1:0] idle_code);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(rrts_pkg::CFG_TASKS_IN_USE, {12'd0, ring});
        write_reg(rrts_pkg::CFG_QUEUE_CAP, {8'd0, cap});
        write_reg(rrts_pkg::CFG_WAIT_FOREVER, idle_code);
    endtask

    // Target task: mostly inside the ring, sometimes any slot.
    function automatic logic [rrts_pkg::TASK_W-1:0] pick_target();
        if ($urandom_range(99) < 85)
            return rrts_pkg::TASK_W'($urandom_range(ring_len() - 1));
        return rrts_pkg::TASK_W'($urandom_range(7));
    endfunction

    // Delay for sleep and done: mostly short, with the special codes mixed in.
    function automatic logic [rrts_pkg::VALUE_W-1:0] pick_delay();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return cfg_forever;
            2:       return rrts_pkg::VALUE_W'($urandom);
            default: return rrts_pkg::VALUE_W'($urandom_range(4, 1));
        endcase
    endfunction

    // One short kernel-like event sequence with random content, or random noise.
    task automatic run_scenario();
        int unsigned reps;
        logic [rrts_pkg::TASK_W-1:0] who;
        case ($urandom_range(9))
            0, 1:
            begin
                // Message burst followed by dispatches.
                reps = $urandom_range(4, 1);
                repeat (reps)
                    send_event(rrts_pkg::OP_SEND, pick_target(),
                               rrts_pkg::VALUE_W'($urandom), 1'($urandom));
                reps = $urandom_range(3, 1);
                repeat (reps)
                    send_event(rrts_pkg::OP_PICK, 3'($urandom),
                               rrts_pkg::VALUE_W'($urandom), 1'($urandom));
            end
            2, 3:
            begin
                // Timed sleep, a few ticks, then dispatch.
                send_event(rrts_pkg::OP_SLEEP, 3'($urandom),
                           ($urandom_range(3) == 0) ? pick_delay()
                                : rrts_pkg::VALUE_W'($urandom_range(5, 1)),
                           1'($urandom));
                reps = $urandom_range(5);
                repeat (reps)
                    send_event(rrts_pkg::OP_TICK, 3'($urandom),
                               rrts_pkg::VALUE_W'($urandom), 1'($urandom));
                reps = $urandom_range(2, 1);
                repeat (reps)
                    send_event(rrts_pkg::OP_PICK, 3'($urandom),
                               rrts_pkg::VALUE_W'($urandom), 1'($urandom));
            end
            4, 5:
            begin
                // Sleep until woken, then a wake with a random type.
                send_event(rrts_pkg::OP_SLEEP, 3'($urandom),
                           ($urandom_range(3) == 0) ? pick_delay() : cfg_forever,
                           1'($urandom));
                who = ($urandom_range(9) < 7) ? running_task[rrts_pkg::TASK_W-1:0]
                                              : pick_target();
                send_event(rrts_pkg::OP_WAKE, who, rrts_pkg::VALUE_W'($urandom),
                           1'($urandom));
                if ($urandom_range(1))
                    send_event(rrts_pkg::OP_TICK, 3'($urandom),
                               rrts_pkg::VALUE_W'($urandom), 1'($urandom));
                send_event(rrts_pkg::OP_PICK, 3'($urandom), rrts_pkg::VALUE_W'($urandom),
                           1'($urandom));
            end
            6, 7:
            begin
                // Dispatch, task returns a delay, then time passes.
                send_event(rrts_pkg::OP_PICK, 3'($urandom), rrts_pkg::VALUE_W'($urandom),
                           1'($urandom));
                send_event(rrts_pkg::OP_DONE, 3'($urandom), pick_delay(), 1'($urandom));
                reps = $urandom_range(2);
                repeat (reps)
                    send_event(rrts_pkg::OP_TICK, 3'($urandom),
                               rrts_pkg::VALUE_W'($urandom), 1'($urandom));
                send_event(rrts_pkg::OP_PICK, 3'($urandom), rrts_pkg::VALUE_W'($urandom),
                           1'($urandom));
            end
            default:
            begin
                // Unstructured events, spare opcodes included.
                reps = $urandom_range(3, 1);
                repeat (reps)
                    send_event(rrts_pkg::OPCODE_W'($urandom), 3'($urandom),
                               rrts_pkg::VALUE_W'($urandom), 1'($urandom));
            end
        endcase
    endtask

    // Random traffic for a given number of events, with an occasional full drain.
    task automatic run_phase(input int unsigned count);
        int unsigned stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            run_scenario();
            if ($urandom_range(99) < 2)
                wait_for_results();
        end
    endtask

    // Nothing is runnable straight after reset: one full lap back to the last task.
    task automatic test_reset_state();
        send_event(rrts_pkg::OP_PICK, 3'd0, 16'd0, 1'b0);
    endtask

    // Every opcode under the reset configuration, with the delay special cases.
    task automatic test_basic_events();
        send_event(rrts_pkg::OP_SEND, 3'd7, 16'hFFFF, 1'b1);
        send_event(rrts_pkg::OP_PICK, 3'd7, 16'hFFFF, 1'b1);
        send_event(rrts_pkg::OP_SLEEP, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_PICK, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_DONE, 3'd0, 16'd3, 1'b0);
        repeat (3)
            send_event(rrts_pkg::OP_TICK, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_PICK, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_SLEEP, 3'd0, cfg_forever, 1'b1);
        send_event(rrts_pkg::OP_WAKE, 3'd7, 16'hFFFF, 1'b0);
        send_event(rrts_pkg::OP_PICK, 3'd0, 16'd0, 1'b0);
        // Wake to an awake task has no effect.
        send_event(rrts_pkg::OP_WAKE, 3'd3, 16'h1234, 1'b0);
        send_event(OP_SPARE_LO, 3'd7, 16'hFFFF, 1'b1);
        send_event(OP_SPARE_HI, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_SEND, 3'd0, 16'd0, 1'b0);
        // Switching inhibited with nothing runnable.
        send_event(rrts_pkg::OP_SLEEP, 3'd0, 16'h8000, 1'b0);
        send_event(rrts_pkg::OP_PICK, 3'd0, 16'd0, 1'b0);
    endtask

    // One-task ring, zero capacity: rejects, and a current task left outside the ring.
    task automatic test_ring_limits();
        set_config(4'd1, 8'd0, 16'd1);
        write_reg(CFG_SPARE, rrts_pkg::VALUE_W'($urandom));
        send_event(rrts_pkg::OP_SEND, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_SEND, 3'd5, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_PICK, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_WAKE, 3'd7, 16'hBEEF, 1'b0);
        send_event(rrts_pkg::OP_DONE, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_PICK, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_PICK, 3'd0, 16'd0, 1'b0);
        send_event(rrts_pkg::OP_DONE, 3'd0, 16'd1, 1'b0);
    endtask

    // Random traffic across ring sizes, capacities and wait-forever codes.
    task automatic test_random_traffic();
        set_config(4'd8, 8'd2, 16'hFFFF);
        run_phase(180);
        set_config(4'd1, 8'd0, 16'd1);
        run_phase(120);
        set_config(4'd15, 8'd255, 16'd3);
        run_phase(180);
        set_config(4'd0, 8'd1, 16'd2);
        run_phase(120);
        set_config(4'd3, 8'd4, rrts_pkg::VALUE_W'($urandom_range(65535, 1)));
        run_phase(180);
        set_config(4'd5, 8'd3, rrts_pkg::VALUE_W'($urandom_range(6, 1)));
        run_phase(180);
        set_config(rrts_pkg::TIU_W'($urandom_range(8, 2)),
                   rrts_pkg::COUNT_W'($urandom_range(5, 1)), 16'hFFFF);
        run_phase(180);
    endtask

    // The receiver holds off while events keep coming, so the input stalls.
    task automatic test_output_stall();
        int unsigned stop_at;
        set_config(4'd8, 8'd4, 16'hFFFF);
        stall_requests++;
        stop_at = items_sent + 30;
        while (items_sent < stop_at)
            run_scenario();
        wait_for_results();
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_steady_stream();
        set_config(4'd6, 8'd3, 16'd2);
        steady_stream = 1'b1;
        run_phase(220);
        wait_for_results();
        steady_stream = 1'b0;
    endtask

    // Test sequence.
    initial
    begin
        clear_slots();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_basic_events();
        test_ring_limits();
        test_random_traffic();
        test_output_stall();
        test_steady_stream();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("round_robin_task_scheduler_unit test passed");
        else
            $display("round_robin_task_scheduler_unit test failed");
        $finish;
    end

endmodule
